// File: rtl/brvm_pkg.sv
// ============================================================================
// brvm_pkg : shared types and constants of the byte-register VM core
// Opcodes, status codes and the execute-unit control word.
// ============================================================================
package brvm_pkg;

    localparam int REG_COUNT = 256;
    localparam int REG_AW    = 8;
    localparam int IO_W      = 13;

    localparam logic [7:0] OP_HALT   = 8'h00;
    localparam logic [7:0] OP_LOAD   = 8'h10;
    localparam logic [7:0] OP_STORE  = 8'h20;
    localparam logic [7:0] OP_MOVE   = 8'h30;
    localparam logic [7:0] OP_IMM    = 8'h40;
    localparam logic [7:0] OP_ADD    = 8'h50;
    localparam logic [7:0] OP_SUB    = 8'h60;
    localparam logic [7:0] OP_GT     = 8'h70;
    localparam logic [7:0] OP_GE     = 8'h80;
    localparam logic [7:0] OP_EQ     = 8'h90;
    localparam logic [7:0] OP_BRANCH = 8'ha0;
    localparam logic [7:0] OP_JUMP   = 8'hb0;
    localparam logic [7:0] OP_PUT    = 8'hc0;
    localparam logic [7:0] OP_GET    = 8'hd0;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_ILLEGAL = 3'd2,
        ST_BADADDR = 3'd3,
        ST_PUT     = 3'd4,
        ST_GET     = 3'd5,
        ST_HALTED  = 3'd6
    } status_t;

    // Control word from the execute unit to the pipeline
    typedef struct packed {
        status_t             status;
        logic                reg_we;
        logic                mem_we;
        logic                load;
        logic                halt_set;
        logic [IO_W-1:0]     io;
        logic [REG_AW-1:0]   dest;
        logic [31:0]         value;
    } exec_ctl_t;

    // First read port takes operand A for these opcodes, operand B otherwise
    function automatic logic rd0_uses_a(input logic [7:0] op);
        rd0_uses_a = op inside {OP_STORE, OP_BRANCH, OP_PUT, OP_GET};
    endfunction

endpackage

// File: rtl/byte_register_vm_execute_core.sv
// ============================================================================
// byte_register_vm_execute_core : byte-register VM execution core
// Executes one 32-bit instruction word per input and reports its effects.
// ============================================================================
// Usage:
//   Input channel instr_valid/instr_ready carries one instruction word,
//   fetched at the pc last reported. Output channel result_valid/result_ready
//   carries one result word per instruction: next pc, status, I/O address
//   and the register write performed.
//   Path: register file read on the accepting edge, then execute into the
//   output register; a load instead takes a data memory read through the
//   load completion stage before the output register.
//   Throughput: one instruction per cycle while the output is not stalled;
//   a load holds the input while its data memory read is outstanding.
//   Back-to-back dependencies are served by forwarding the last register write.
//   Reset: pc, halted flag and pipeline clear at once; then a clearing pass
//   zeroes the data memory, and the register file while its counter is
//   below REG_COUNT. No input word is taken during the pass.
//   Stall: a result waiting in the output register blocks execute (not a
//   load's memory read) but not acceptance of the next word into it.
// ============================================================================
module byte_register_vm_execute_core #(
    parameter int CODE_WORDS = 1024,
    parameter int DATA_BYTES = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          instr_valid,
    output logic                          instr_ready,
    input  logic [31:0]                   instr_word,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [$clog2(CODE_WORDS)-1:0] next_pc,
    output logic [2:0]                    status,
    output logic [brvm_pkg::IO_W-1:0]     io_address,
    output logic                          reg_written,
    output logic [brvm_pkg::REG_AW-1:0]   dest_reg,
    output logic [31:0]                   dest_value
);

    localparam int PC_W    = $clog2(CODE_WORDS);
    localparam int DATA_AW = $clog2(DATA_BYTES);
    localparam int REG_AW  = brvm_pkg::REG_AW;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [PC_W-1:0]     pc_reg,  pc_next;
    logic                halted_reg, halted_next;

    // execute stage (instruction whose register reads are in flight)
    logic                s1_valid_reg, s1_valid_next;
    logic [31:0]         s1_instr_reg;

    // load completion stage
    logic                s2_valid_reg, s2_valid_next;
    logic [PC_W-1:0]     s2_pc_reg;
    logic [REG_AW-1:0]   s2_dest_reg;

    // last register write, captured at the edge a word enters execute
    logic                fwd_valid_reg;
    logic [REG_AW-1:0]   fwd_addr_reg;
    logic [31:0]         fwd_data_reg;

    // clearing pass
    logic [DATA_AW-1:0]  clr_cnt_reg;
    logic                clr_done_reg;

    // output register
    logic                result_valid_reg, result_valid_next;
    logic [PC_W-1:0]     next_pc_reg;
    logic [2:0]          status_reg;
    logic [brvm_pkg::IO_W-1:0] io_address_reg;
    logic                reg_written_reg;
    logic [REG_AW-1:0]   dest_reg_reg;
    logic [31:0]         dest_value_reg;

    // ------------------------------------------------------------------
    // Combinational nets
    // ------------------------------------------------------------------
    logic                in_fire;
    logic                out_free;
    logic                s1_go;
    logic                s2_fire;
    logic                out_load_s1;

    logic [REG_AW-1:0]   rd0_addr_in,  rd1_addr_in;
    logic [REG_AW-1:0]   rd0_addr_s1,  rd1_addr_s1;
    logic [31:0]         rf0_rdata, rf1_rdata;
    logic [31:0]         op0, op1;

    logic                rf_we;
    logic                rf_we_run;
    logic [REG_AW-1:0]   rf_waddr;
    logic [31:0]         rf_wdata;

    logic                dm_we;
    logic [DATA_AW-1:0]  dm_waddr;
    logic [7:0]          dm_wdata;
    logic                dm_re;
    logic [7:0]          dm_rdata;

    logic                clr_reg_phase;

    logic [PC_W-1:0]     ex_next_pc;
    brvm_pkg::exec_ctl_t ex_ctl;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign out_free = !result_valid_reg || result_ready;
    assign s2_fire  = s2_valid_reg && out_free;
    // a load moves on to its memory read whatever the output does
    assign s1_go    = s1_valid_reg && !s2_valid_reg && (ex_ctl.load || out_free);
    assign out_load_s1 = s1_go && !ex_ctl.load;

    // Take a word only when execute will be free and no load is left behind,
    // so the sole register write it can miss is the one on its own edge.
    assign instr_ready = clr_done_reg &&
                         ((!s1_valid_reg && (!s2_valid_reg || s2_fire)) ||
                          out_load_s1);
    assign in_fire     = instr_valid && instr_ready;

    // ------------------------------------------------------------------
    // Register file: two copies, one per read port, written alike
    // ------------------------------------------------------------------
    assign rd0_addr_in = brvm_pkg::rd0_uses_a(instr_word[7:0]) ? instr_word[15:8]
                                                                : instr_word[23:16];
    assign rd1_addr_in = (instr_word[7:0] == brvm_pkg::OP_STORE) ? instr_word[23:16]
                                                                  : instr_word[31:24];
    assign rd0_addr_s1 = brvm_pkg::rd0_uses_a(s1_instr_reg[7:0]) ? s1_instr_reg[15:8]
                                                                  : s1_instr_reg[23:16];
    assign rd1_addr_s1 = (s1_instr_reg[7:0] == brvm_pkg::OP_STORE) ? s1_instr_reg[23:16]
                                                                    : s1_instr_reg[31:24];

    // clear the register file while the pass counter is below REG_COUNT
    assign clr_reg_phase = {1'b0, clr_cnt_reg} < (DATA_AW + 1)'(brvm_pkg::REG_COUNT);

    // load completion and a plain write never share an edge
    assign rf_we_run = s2_fire || (s1_go && ex_ctl.reg_we);
    assign rf_we     = clr_done_reg ? rf_we_run : clr_reg_phase;
    assign rf_waddr  = !clr_done_reg ? clr_cnt_reg[REG_AW-1:0] :
                       s2_fire       ? s2_dest_reg : s1_instr_reg[15:8];
    assign rf_wdata  = !clr_done_reg ? 32'd0 :
                       s2_fire       ? 32'(dm_rdata) : ex_ctl.value;

    brvm_ram #(
        .WIDTH (32),
        .DEPTH (brvm_pkg::REG_COUNT)
    ) u_rf0 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_fire),
        .raddr (rd0_addr_in),
        .rdata (rf0_rdata)
    );

    brvm_ram #(
        .WIDTH (32),
        .DEPTH (brvm_pkg::REG_COUNT)
    ) u_rf1 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_fire),
        .raddr (rd1_addr_in),
        .rdata (rf1_rdata)
    );

    // forward the write that coincided with the read
    assign op0 = (fwd_valid_reg && fwd_addr_reg == rd0_addr_s1) ? fwd_data_reg : rf0_rdata;
    assign op1 = (fwd_valid_reg && fwd_addr_reg == rd1_addr_s1) ? fwd_data_reg : rf1_rdata;

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    brvm_exec #(
        .CODE_WORDS (CODE_WORDS),
        .DATA_BYTES (DATA_BYTES)
    ) u_exec (
        .instr   (s1_instr_reg),
        .op0     (op0),
        .op1     (op1),
        .pc      (pc_reg),
        .halted  (halted_reg),
        .next_pc (ex_next_pc),
        .ctl     (ex_ctl)
    );

    // ------------------------------------------------------------------
    // Data memory
    // ------------------------------------------------------------------
    assign dm_we    = clr_done_reg ? (s1_go && ex_ctl.mem_we) : 1'b1;
    assign dm_waddr = clr_done_reg ? op0[DATA_AW-1:0] : clr_cnt_reg;
    assign dm_wdata = clr_done_reg ? op1[7:0] : 8'd0;
    assign dm_re    = s1_go && ex_ctl.load;

    brvm_ram #(
        .WIDTH (8),
        .DEPTH (DATA_BYTES)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (op0[DATA_AW-1:0]),
        .rdata (dm_rdata)
    );

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        pc_next     = pc_reg;
        halted_next = halted_reg;
        if (s1_go)
        begin
            pc_next     = ex_next_pc;
            halted_next = halted_reg || ex_ctl.halt_set;
        end

        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (dm_re)
            s2_valid_next = 1'b1;
        else if (s2_fire)
            s2_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (s2_fire || out_load_s1)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= '0;
            halted_reg       <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            clr_cnt_reg      <= '0;
            clr_done_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg           <= pc_next;
            halted_reg       <= halted_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
            if (in_fire)
                fwd_valid_reg <= rf_we_run;
            // advance the clearing pass, then hold
            if (!clr_done_reg)
            begin
                if (clr_cnt_reg == DATA_AW'(DATA_BYTES - 1))
                    clr_done_reg <= 1'b1;
                else
                    clr_cnt_reg <= clr_cnt_reg + DATA_AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_instr_reg <= instr_word;
            fwd_addr_reg <= rf_waddr;
            fwd_data_reg <= rf_wdata;
        end
        if (dm_re)
        begin
            s2_pc_reg   <= ex_next_pc;
            s2_dest_reg <= ex_ctl.dest;
        end
        if (s2_fire)
        begin
            next_pc_reg     <= s2_pc_reg;
            status_reg      <= brvm_pkg::ST_OK;
            io_address_reg  <= '0;
            reg_written_reg <= 1'b1;
            dest_reg_reg    <= s2_dest_reg;
            dest_value_reg  <= 32'(dm_rdata);
        end
        else if (out_load_s1)
        begin
            next_pc_reg     <= ex_next_pc;
            status_reg      <= ex_ctl.status;
            io_address_reg  <= ex_ctl.io;
            reg_written_reg <= ex_ctl.reg_we;
            dest_reg_reg    <= ex_ctl.dest;
            dest_value_reg  <= ex_ctl.value;
        end
    end

    assign result_valid = result_valid_reg;
    assign next_pc      = next_pc_reg;
    assign status       = status_reg;
    assign io_address   = io_address_reg;
    assign reg_written  = reg_written_reg;
    assign dest_reg     = dest_reg_reg;
    assign dest_value   = dest_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a load awaiting its data never has a younger word in execute
    a_single_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s2_valid_reg))
        else $error("execute and load stages occupied together");

    // once halted, the core stays halted with the pc frozen
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> (halted_reg && $stable(pc_reg)))
        else $error("halted core changed state");

    // nothing is in flight while the memories are being cleared
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done_reg |-> (!s1_valid_reg && !s2_valid_reg && !result_valid_reg))
        else $error("work in flight during clearing pass");

    // a word executed while halted reports no register write
    a_halted_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == brvm_pkg::ST_HALTED) |-> !reg_written)
        else $error("register write reported while halted");

endmodule

// File: rtl/brvm_ram.sv
// ============================================================================
// brvm_ram : generic single-write, single-read synchronous RAM
// Read data is registered and holds while no read is issued.
// ============================================================================
module brvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/brvm_exec.sv
// ============================================================================
// brvm_exec : instruction decode and execute
// Works out next pc, status, register and memory effects of one instruction.
// ============================================================================
module brvm_exec #(
    parameter int CODE_WORDS = 1024,
    parameter int DATA_BYTES = 8192
) (
    input  logic [31:0]                   instr,
    input  logic [31:0]                   op0,
    input  logic [31:0]                   op1,
    input  logic [$clog2(CODE_WORDS)-1:0] pc,
    input  logic                          halted,
    output logic [$clog2(CODE_WORDS)-1:0] next_pc,
    output brvm_pkg::exec_ctl_t           ctl
);

    localparam int PC_W = $clog2(CODE_WORDS);

    logic [7:0]      op;
    logic [7:0]      fa;
    logic [7:0]      fb;
    logic [7:0]      fc;
    logic            in_range;
    logic [PC_W-1:0] pc_inc;

    assign op = instr[7:0];
    assign fa = instr[15:8];
    assign fb = instr[23:16];
    assign fc = instr[31:24];

    assign in_range = op0 < 32'(DATA_BYTES);
    assign pc_inc   = (pc == PC_W'(CODE_WORDS - 1)) ? '0 : pc + PC_W'(1);

    always_comb
    begin
        next_pc      = pc_inc;
        ctl.status   = brvm_pkg::ST_OK;
        ctl.reg_we   = 1'b0;
        ctl.mem_we   = 1'b0;
        ctl.load     = 1'b0;
        ctl.halt_set = 1'b0;
        ctl.io       = '0;
        ctl.value    = '0;
        if (halted)
        begin
            next_pc    = pc;
            ctl.status = brvm_pkg::ST_HALTED;
        end
        else
        begin
            case (op)
                brvm_pkg::OP_HALT:
                begin
                    next_pc      = pc;
                    ctl.halt_set = 1'b1;
                    ctl.status   = brvm_pkg::ST_HALT;
                end
                brvm_pkg::OP_LOAD:
                begin
                    if (in_range)
                        ctl.load = 1'b1;
                    else
                        ctl.status = brvm_pkg::ST_BADADDR;
                end
                brvm_pkg::OP_STORE:
                begin
                    if (in_range)
                        ctl.mem_we = 1'b1;
                    else
                        ctl.status = brvm_pkg::ST_BADADDR;
                end
                brvm_pkg::OP_MOVE:
                begin
                    ctl.reg_we = 1'b1;
                    ctl.value  = op0;
                end
                brvm_pkg::OP_IMM:
                begin
                    ctl.reg_we = 1'b1;
                    ctl.value  = 32'(fb);
                end
                brvm_pkg::OP_ADD:
                begin
                    ctl.reg_we = 1'b1;
                    ctl.value  = op0 + op1;
                end
                brvm_pkg::OP_SUB:
                begin
                    ctl.reg_we = 1'b1;
                    ctl.value  = op0 - op1;
                end
                brvm_pkg::OP_GT:
                begin
                    ctl.reg_we = 1'b1;
                    ctl.value  = 32'(op0 > op1);
                end
                brvm_pkg::OP_GE:
                begin
                    ctl.reg_we = 1'b1;
                    ctl.value  = 32'(op0 >= op1);
                end
                brvm_pkg::OP_EQ:
                begin
                    ctl.reg_we = 1'b1;
                    ctl.value  = 32'(op0 == op1);
                end
                brvm_pkg::OP_BRANCH:
                begin
                    next_pc = (op0 != 32'd0) ? PC_W'(fb) : PC_W'(fc);
                end
                brvm_pkg::OP_JUMP:
                begin
                    next_pc = PC_W'(fa);
                end
                brvm_pkg::OP_PUT, brvm_pkg::OP_GET:
                begin
                    if (in_range)
                    begin
                        ctl.status = (op == brvm_pkg::OP_PUT) ? brvm_pkg::ST_PUT
                                                              : brvm_pkg::ST_GET;
                        ctl.io     = op0[brvm_pkg::IO_W-1:0];
                    end
                    else
                    begin
                        ctl.status = brvm_pkg::ST_BADADDR;
                    end
                end
                default:
                begin
                    ctl.status = brvm_pkg::ST_ILLEGAL;
                end
            endcase
        end
        // destination is reported only for a completed register write
        ctl.dest = (ctl.reg_we || ctl.load) ? fa : '0;
    end

endmodule

// File: verif/byte_register_vm_execute_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// byte_register_vm_execute_core_tb : self-checking bench for the VM core
// Feeds instruction words through the valid/ready input, retires each one in
// a bench-side architectural model (pc, register file, data memory, halted
// flag) and checks every result word against the oldest retired prediction.
// Runs directed corner cases, then phases of random programs under varying
// idle and stall rates, a long output hold-off, and halts at the very end.
// ============================================================================
module byte_register_vm_execute_core_tb;

    localparam int CODE_WORDS  = 1024;
    localparam int DATA_BYTES  = 8192;
    localparam int PC_W        = $clog2(CODE_WORDS);
    localparam int IO_W        = brvm_pkg::IO_W;
    localparam int REG_AW      = brvm_pkg::REG_AW;
    localparam int REG_COUNT   = brvm_pkg::REG_COUNT;
    // Reset clearing pass plus ~1000 words under heavy stalls, several times over
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 10;

    // One retired instruction as seen on the result channel
    typedef struct packed {
        logic [PC_W-1:0]   pc;
        brvm_pkg::status_t st;
        logic [IO_W-1:0]   io;
        logic              wr;
        logic [REG_AW-1:0] dst;
        logic [31:0]       val;
    } retire_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  instr_valid  = 1'b0;
    logic                  instr_ready;
    logic [31:0]           instr_word   = 32'h0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [PC_W-1:0]       next_pc;
    logic [2:0]            status;
    logic [IO_W-1:0]       io_address;
    logic                  reg_written;
    logic [REG_AW-1:0]     dest_reg;
    logic [31:0]           dest_value;

    // Architectural state of the bench-side model
    logic [PC_W-1:0]       arch_pc;
    logic [31:0]           arch_regs [REG_COUNT];
    logic [7:0]            arch_mem  [DATA_BYTES];
    logic                  arch_halted;

    logic [31:0]           program_q [$];
    retire_t               retire_q  [$];

    int                    send_idle_pct  = 0;
    int                    sink_stall_pct = 0;
    int                    hold_req       = 0;
    int                    hold_seen      = 0;
    int                    hold_left      = 0;
    int                    cycle_count    = 0;
    int                    fail_count     = 0;
    int                    emitted        = 0;
    logic                  word_taken     = 1'b0;

    byte_register_vm_execute_core #(
        .CODE_WORDS (CODE_WORDS),
        .DATA_BYTES (DATA_BYTES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .instr_word   (instr_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .next_pc      (next_pc),
        .status       (status),
        .io_address   (io_address),
        .reg_written  (reg_written),
        .dest_reg     (dest_reg),
        .dest_value   (dest_value)
    );

    always #10 clk = ~clk;

    // Pack an instruction: opcode in the low byte, operands A, B, C above it
    function automatic logic [31:0] mk(input logic [7:0] op, input logic [7:0] a,
                                       input logic [7:0] b, input logic [7:0] c);
        mk = {c, b, a, op};
    endfunction

    // Random operand byte
    function automatic logic [7:0] rnd8();
        rnd8 = 8'($urandom_range(0, 255));
    endfunction

    // Mostly a small pool so that back-to-back dependencies are common
    function automatic logic [7:0] pick_reg();
        logic [7:0] r;
        if ($urandom_range(0, 3) == 0)
            r = 8'($urandom_range(0, 255));
        else
            r = 8'($urandom_range(0, 7));
        pick_reg = r;
    endfunction

    // Retire one instruction in the model and produce its result word
    task automatic retire_instr(input logic [31:0] w, output retire_t r);
        logic [7:0]      op;
        logic [7:0]      a;
        logic [7:0]      b;
        logic [7:0]      c;
        logic [31:0]     addr;
        logic [PC_W-1:0] nxt;
        op   = w[7:0];
        a    = w[15:8];
        b    = w[23:16];
        c    = w[31:24];
        r    = '0;
        r.st = brvm_pkg::ST_OK;
        nxt  = arch_pc + 1'b1;
        if (arch_halted)
        begin
            nxt  = arch_pc;
            r.st = brvm_pkg::ST_HALTED;
        end
        else
        begin
            case (op)
                brvm_pkg::OP_HALT:
                begin
                    arch_halted = 1'b1;
                    nxt  = arch_pc;
                    r.st = brvm_pkg::ST_HALT;
                end
                brvm_pkg::OP_LOAD:
                begin
                    addr = arch_regs[b];
                    if (addr >= DATA_BYTES)
                    begin
                        r.st = brvm_pkg::ST_BADADDR;
                    end
                    else
                    begin
                        r.wr  = 1'b1;
                        r.val = {24'h0, arch_mem[addr[IO_W-1:0]]};
                    end
                end
                brvm_pkg::OP_STORE:
                begin
                    addr = arch_regs[a];
                    if (addr >= DATA_BYTES)
                        r.st = brvm_pkg::ST_BADADDR;
                    else
                        arch_mem[addr[IO_W-1:0]] = arch_regs[b][7:0];
                end
                brvm_pkg::OP_MOVE:
                begin
                    r.wr  = 1'b1;
                    r.val = arch_regs[b];
                end
                brvm_pkg::OP_IMM:
                begin
                    r.wr  = 1'b1;
                    r.val = {24'h0, b};
                end
                brvm_pkg::OP_ADD:
                begin
                    r.wr  = 1'b1;
                    r.val = arch_regs[b] + arch_regs[c];
                end
                brvm_pkg::OP_SUB:
                begin
                    r.wr  = 1'b1;
                    r.val = arch_regs[b] - arch_regs[c];
                end
                brvm_pkg::OP_GT:
                begin
                    r.wr  = 1'b1;
                    r.val = {31'h0, arch_regs[b] > arch_regs[c]};
                end
                brvm_pkg::OP_GE:
                begin
                    r.wr  = 1'b1;
                    r.val = {31'h0, arch_regs[b] >= arch_regs[c]};
                end
                brvm_pkg::OP_EQ:
                begin
                    r.wr  = 1'b1;
                    r.val = {31'h0, arch_regs[b] == arch_regs[c]};
                end
                brvm_pkg::OP_BRANCH:
                    nxt = (arch_regs[a] != 32'h0) ? PC_W'(b) : PC_W'(c);
                brvm_pkg::OP_JUMP:
                    nxt = PC_W'(a);
                brvm_pkg::OP_PUT, brvm_pkg::OP_GET:
                begin
                    addr = arch_regs[a];
                    if (addr >= DATA_BYTES)
                    begin
                        r.st = brvm_pkg::ST_BADADDR;
                    end
                    else
                    begin
                        r.st = (op == brvm_pkg::OP_PUT) ? brvm_pkg::ST_PUT
                                                        : brvm_pkg::ST_GET;
                        r.io = addr[IO_W-1:0];
                    end
                end
                default:
                    r.st = brvm_pkg::ST_ILLEGAL;
            endcase
            if (r.wr)
            begin
                arch_regs[a] = r.val;
                r.dst = a;
            end
        end
        arch_pc = nxt;
        r.pc    = nxt;
    endtask

    task automatic emit(input logic [31:0] w);
        program_q.push_back(w);
        emitted++;
    endtask

    // Random programs: mostly well-formed address build / store / load chains
    // and arithmetic on a small register pool, with broken addresses and noise
    task automatic gen_program(input int n);
        int          goal;
        int          kind;
        int          k;
        logic [7:0]  ra;
        logic [7:0]  rb;
        logic [7:0]  rc;
        logic [7:0]  io_op;
        logic [31:0] w;
        goal = emitted + n;
        while (emitted < goal)
        begin
            kind  = $urandom_range(0, 99);
            ra    = pick_reg();
            rb    = pick_reg();
            rc    = pick_reg();
            io_op = ($urandom_range(0, 1) == 1) ? brvm_pkg::OP_PUT : brvm_pkg::OP_GET;
            if (kind < 30)
            begin
                // Build an address by doubling, store a byte there, read it back
                emit(mk(brvm_pkg::OP_IMM, ra, rnd8(), rnd8()));
                k = $urandom_range(0, 5);
                repeat (k) emit(mk(brvm_pkg::OP_ADD, ra, ra, ra));
                if ($urandom_range(0, 1) == 1)
                begin
                    emit(mk(brvm_pkg::OP_IMM, rb, rnd8(), rnd8()));
                    emit(mk(brvm_pkg::OP_ADD, ra, ra, rb));
                end
                emit(mk(brvm_pkg::OP_IMM, rb, rnd8(), rnd8()));
                emit(mk(brvm_pkg::OP_STORE, ra, rb, rnd8()));
                if ($urandom_range(0, 2) == 0)
                    emit(mk(brvm_pkg::OP_MOVE, rc, rb, rnd8()));
                emit(mk(brvm_pkg::OP_LOAD, rc, ra, rnd8()));
                if ($urandom_range(0, 3) == 0)
                    emit(mk(io_op, ra, rnd8(), rnd8()));
            end
            else if (kind < 55)
            begin
                case ($urandom_range(0, 6))
                    0:       w = mk(brvm_pkg::OP_MOVE, ra, rb, rc);
                    1:       w = mk(brvm_pkg::OP_IMM, ra, rnd8(), rc);
                    2:       w = mk(brvm_pkg::OP_ADD, ra, rb, rc);
                    3:       w = mk(brvm_pkg::OP_SUB, ra, rb, rc);
                    4:       w = mk(brvm_pkg::OP_GT, ra, rb, rc);
                    5:       w = mk(brvm_pkg::OP_GE, ra, rb, rc);
                    default: w = mk(brvm_pkg::OP_EQ, ra, rb, rc);
                endcase
                emit(w);
            end
            else if (kind < 65)
            begin
                if ($urandom_range(0, 1) == 1)
                    emit(mk(brvm_pkg::OP_BRANCH, ra, rnd8(), rnd8()));
                else
                    emit(mk(brvm_pkg::OP_JUMP, rnd8(), rnd8(), rnd8()));
            end
            else if (kind < 75)
            begin
                emit(mk(io_op, ra, rb, rc));
            end
            else if (kind < 85)
            begin
                // Subtract a nonzero immediate so the result may wrap below zero, then aim a memory or I/O access at it
                emit(mk(brvm_pkg::OP_IMM, rb, 8'($urandom_range(1, 255)), rc));
                emit(mk(brvm_pkg::OP_SUB, ra, rc, rb));
                case ($urandom_range(0, 3))
                    0:       w = mk(brvm_pkg::OP_LOAD, rc, ra, rb);
                    1:       w = mk(brvm_pkg::OP_STORE, ra, rb, rc);
                    2:       w = mk(brvm_pkg::OP_PUT, ra, rb, rc);
                    default: w = mk(brvm_pkg::OP_GET, ra, rb, rc);
                endcase
                emit(w);
            end
            else
            begin
                // Raw noise, never a halt so that the run keeps going
                w = $urandom;
                if (w[7:0] == brvm_pkg::OP_HALT)
                    w[7:0] = 8'hff;
                emit(w);
            end
        end
    endtask

    // Hold until the input queue is empty and every result has come back
    task automatic drain();
        while (program_q.size() != 0 || instr_valid || retire_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next word at the falling edge once the current one
    // has been taken; hold valid and payload steady until then.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!instr_valid || word_taken))
        begin
            if (program_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                instr_valid <= 1'b1;
                instr_word  <= program_q.pop_front();
            end
            else
            begin
                instr_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus a long hold-off counted here on
    // request so that the core backs up and stalls its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen    <= hold_req;
            hold_left    <= LONG_HOLD;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check the result word first (it belongs to an older
    // instruction), then retire any word taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        retire_t got;
        retire_t want;
        retire_t fresh;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got.pc  = next_pc;
                got.st  = brvm_pkg::status_t'(status);
                got.io  = io_address;
                got.wr  = reg_written;
                got.dst = dest_reg;
                got.val = dest_value;
                if (retire_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result word: pc=%0d st=%0d io=%0d wr=%0d rd=%0d val=%h",
                                 got.pc, got.st, got.io, got.wr, got.dst, got.val);
                end
                else
                begin
                    want = retire_q.pop_front();
                    if (got.pc !== want.pc || got.st !== want.st || got.io !== want.io ||
                        got.wr !== want.wr || got.dst !== want.dst || got.val !== want.val)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("mismatch exp: pc=%0d st=%0d io=%0d wr=%0d rd=%0d val=%h",
                                     want.pc, want.st, want.io, want.wr, want.dst, want.val);
                            $display("         got: pc=%0d st=%0d io=%0d wr=%0d rd=%0d val=%h",
                                     got.pc, got.st, got.io, got.wr, got.dst, got.val);
                        end
                    end
                end
            end
            word_taken = instr_valid && instr_ready;
            if (word_taken)
            begin
                retire_instr(instr_word, fresh);
                retire_q.push_back(fresh);
            end
        end
        else
        begin
            word_taken = 1'b0;
        end
    end

    // Watchdog: drop the run if it overstays the cycle budget
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, directed cases, random phases, halt at the end.
    // ------------------------------------------------------------------
    initial
    begin
        arch_pc     = '0;
        arch_halted = 1'b0;
        for (int i = 0; i < REG_COUNT; i++)
            arch_regs[i] = 32'h0;
        for (int i = 0; i < DATA_BYTES; i++)
            arch_mem[i] = 8'h0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: operand extremes, every opcode but halt, bad and edge addresses.
        // Addresses 8191 and 8192 are built by doubling 255 to 8160, then adding 31 and 32.
        emit(mk(brvm_pkg::OP_IMM,    8'd1,   8'd255, 8'd0));
        emit(mk(brvm_pkg::OP_ADD,    8'd2,   8'd1,   8'd1));
        emit(mk(brvm_pkg::OP_SUB,    8'd3,   8'd0,   8'd1));
        emit(mk(brvm_pkg::OP_GT,     8'd4,   8'd3,   8'd1));
        emit(mk(brvm_pkg::OP_GE,     8'd5,   8'd1,   8'd1));
        emit(mk(brvm_pkg::OP_EQ,     8'd6,   8'd1,   8'd2));
        emit(mk(brvm_pkg::OP_MOVE,   8'd255, 8'd3,   8'd255));
        emit(mk(brvm_pkg::OP_STORE,  8'd1,   8'd2,   8'd0));
        emit(mk(brvm_pkg::OP_LOAD,   8'd8,   8'd1,   8'd0));
        emit(mk(brvm_pkg::OP_STORE,  8'd3,   8'd1,   8'd0));
        emit(mk(brvm_pkg::OP_LOAD,   8'd9,   8'd255, 8'd0));
        emit(mk(brvm_pkg::OP_ADD,    8'd10,  8'd2,   8'd2));
        emit(mk(brvm_pkg::OP_ADD,    8'd10,  8'd10,  8'd10));
        emit(mk(brvm_pkg::OP_ADD,    8'd10,  8'd10,  8'd10));
        emit(mk(brvm_pkg::OP_ADD,    8'd10,  8'd10,  8'd10));
        emit(mk(brvm_pkg::OP_IMM,    8'd11,  8'd31,  8'd0));
        emit(mk(brvm_pkg::OP_ADD,    8'd12,  8'd10,  8'd11));
        emit(mk(brvm_pkg::OP_STORE,  8'd12,  8'd1,   8'd0));
        emit(mk(brvm_pkg::OP_PUT,    8'd12,  8'd0,   8'd0));
        emit(mk(brvm_pkg::OP_LOAD,   8'd14,  8'd12,  8'd0));
        emit(mk(brvm_pkg::OP_IMM,    8'd11,  8'd32,  8'd0));
        emit(mk(brvm_pkg::OP_ADD,    8'd13,  8'd10,  8'd11));
        emit(mk(brvm_pkg::OP_GET,    8'd13,  8'd0,   8'd0));
        emit(mk(brvm_pkg::OP_GET,    8'd0,   8'd0,   8'd0));
        emit(mk(brvm_pkg::OP_BRANCH, 8'd1,   8'hab,  8'h12));
        emit(mk(brvm_pkg::OP_BRANCH, 8'd0,   8'hff,  8'h00));
        emit(mk(brvm_pkg::OP_JUMP,   8'hff,  8'h00,  8'h00));
        emit(mk(8'hff,               8'h5a,  8'ha5,  8'hff));
        drain();

        // No idling on either side
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        gen_program(230);
        drain();

        // Long output hold-off while words keep coming: fill the core up
        hold_req++;
        gen_program(60);
        drain();

        // Sender idle much of the time
        send_idle_pct  = 56;
        sink_stall_pct = 0;
        gen_program(220);
        drain();

        // Receiver stalling much of the time
        send_idle_pct  = 0;
        sink_stall_pct = 56;
        gen_program(220);
        drain();

        // Light idling on both sides
        send_idle_pct  = 10;
        sink_stall_pct = 10;
        gen_program(220);
        drain();

        // Halt, then words that must all report already halted
        emit(mk(brvm_pkg::OP_HALT, rnd8(), rnd8(), rnd8()));
        emit(mk(brvm_pkg::OP_IMM,  8'd1, 8'd77, 8'd0));
        emit(mk(brvm_pkg::OP_JUMP, 8'd5, 8'd0,  8'd0));
        emit(mk(brvm_pkg::OP_HALT, 8'd0, 8'd0,  8'd0));
        emit($urandom);
        drain();

        // Let any stray result word show up before the verdict
        repeat (20) @(posedge clk);
        if (fail_count == 0 && retire_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/brvm_pkg.sv
rtl/brvm_ram.sv
rtl/brvm_exec.sv
rtl/byte_register_vm_execute_core.sv
verif/byte_register_vm_execute_core_tb.sv
